>>> hdl/cidt_pkg.sv
// Shared types, widths and codes of the CAN identifier dispatch table.
`default_nettype none
package cidt_pkg;

   localparam int ENTRIES = 16;

   localparam int ID_W  = 29;
   localparam int LEN_W = 30;
   localparam int HND_W = 8;
   localparam int CMD_W = 2;
   localparam int KIND_W = 2;

   localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_EXACT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_RANGE = 2'd2;

   localparam logic [KIND_W-1:0] MATCH_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] MATCH_EXACT   = 2'd1;
   localparam logic [KIND_W-1:0] MATCH_RANGE   = 2'd2;
   localparam logic [KIND_W-1:0] MATCH_DEFAULT = 2'd3;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic CSR_DEFAULT_ENABLE  = 1'b0;
   localparam logic CSR_DEFAULT_HANDLER = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  can_id;
      logic [LEN_W-1:0] range_len;
      logic [HND_W-1:0] handler;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [KIND_W-1:0] match_kind;
      logic [HND_W-1:0]  handler_out;
   } rsp_type;

   typedef struct packed {
      logic             enable;
      logic [HND_W-1:0] handler;
   } cfg_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [HND_W-1:0] handler;
   } exact_entry_type;

   typedef struct packed {
      logic [ID_W-1:0]  start;
      logic [LEN_W-1:0] len;
      logic [HND_W-1:0] handler;
   } range_entry_type;

endpackage
`default_nettype wire

>>> hdl/cidt_table.sv
// Append-only entry table: synchronous memory with a fill count.
`default_nettype none
module cidt_table #(
   parameter int ENTRIES = cidt_pkg::ENTRIES,
   parameter int WIDTH = 1,
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CW = $clog2(ENTRIES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data,
   output logic      [CW-1:0]    count
);

   logic [WIDTH-1:0] mem [ENTRIES];
   logic [WIDTH-1:0] rd_data_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign count   = count_ff;

endmodule
`default_nettype wire

>>> hdl/cidt_scan.sv
// Command sequencer: appends entries, scans both tables and holds the result register.
`default_nettype none
module cidt_scan #(
   parameter int ENTRIES = cidt_pkg::ENTRIES,
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CW = $clog2(ENTRIES + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire cidt_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output cidt_pkg::rsp_type               rsp_data,
   input  wire cidt_pkg::cfg_type          cfg,
   input  wire logic [CW-1:0]              exact_count,
   input  wire logic [CW-1:0]              range_count,
   output logic                            exact_wr,
   output logic                            range_wr,
   output cidt_pkg::exact_entry_type       exact_wr_data,
   output cidt_pkg::range_entry_type       range_wr_data,
   output logic [AW-1:0]                   rd_addr,
   input  wire cidt_pkg::exact_entry_type  exact_rd,
   input  wire cidt_pkg::range_entry_type  range_rd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXACT = 4'b0010,
      S_RANGE = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cidt_pkg::req_type req_ff, req_in;
   cidt_pkg::rsp_type res_ff, res_in;
   cidt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       exact_full;
   logic                       range_full;
   logic                       issue_exact;
   logic                       issue_range;
   logic                       exact_hit;
   logic                       range_hit;
   logic [cidt_pkg::LEN_W-1:0] offset;
   logic                       slot_free;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign exact_full  = (exact_count == CW'(ENTRIES));
   assign range_full  = (range_count == CW'(ENTRIES));
   assign issue_exact = (idx_ff < exact_count);
   assign issue_range = (idx_ff < range_count);
   assign rd_addr     = idx_ff[AW-1:0];
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   assign exact_wr = accept && (req_data.cmd == cidt_pkg::CMD_ADD_EXACT) && !exact_full;
   assign range_wr = accept && (req_data.cmd == cidt_pkg::CMD_ADD_RANGE) && !range_full;
   assign exact_wr_data.id      = req_data.can_id;
   assign exact_wr_data.handler = req_data.handler;
   assign range_wr_data.start   = req_data.can_id;
   assign range_wr_data.len     = req_data.range_len;
   assign range_wr_data.handler = req_data.handler;

   assign exact_hit = (exact_rd.id == req_ff.can_id);
   assign offset    = cidt_pkg::LEN_W'(req_ff.can_id) - cidt_pkg::LEN_W'(range_rd.start);
   assign range_hit = (req_ff.can_id >= range_rd.start) && (offset < range_rd.len);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               idx_in  = '0;
               pend_in = 1'b0;
               res_in  = '0;
               unique case (req_data.cmd)
                  cidt_pkg::CMD_LOOKUP: begin
                     state_in = S_EXACT;
                  end
                  cidt_pkg::CMD_ADD_EXACT: begin
                     res_in.status = exact_full ? cidt_pkg::STATUS_FULL : cidt_pkg::STATUS_OK;
                     state_in      = S_DONE;
                  end
                  cidt_pkg::CMD_ADD_RANGE: begin
                     res_in.status = range_full ? cidt_pkg::STATUS_FULL : cidt_pkg::STATUS_OK;
                     state_in      = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_EXACT: begin
            if (pend_ff && exact_hit) begin
               res_in.match_kind  = cidt_pkg::MATCH_EXACT;
               res_in.handler_out = exact_rd.handler;
               state_in           = S_DONE;
            end else if (!issue_exact) begin
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = S_RANGE;
            end else begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
         end
         S_RANGE: begin
            if (pend_ff && range_hit) begin
               res_in.match_kind  = cidt_pkg::MATCH_RANGE;
               res_in.handler_out = range_rd.handler;
               state_in           = S_DONE;
            end else if (!issue_range) begin
               if (cfg.enable) begin
                  res_in.match_kind  = cidt_pkg::MATCH_DEFAULT;
                  res_in.handler_out = cfg.handler;
               end
               state_in = S_DONE;
            end else begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> hdl/can_id_dispatch_table.sv
// Top level of the CAN identifier dispatch table.
//
// req channel (valid/ready): one command per transfer: lookup an identifier,
// add an exact-identifier entry or add a range entry. rsp channel
// (valid/ready): one result per command, in command order.
// csr port: csr_write with csr_index 0 sets default_enable, index 1 sets
// default_handler; write only while no command is in flight.
// An add goes straight to the done state, which raises rsp_valid once the
// rsp register is free. A lookup scans the exact table and then the range
// table one entry per cycle through the memory read port and stops on a
// hit; the done state then raises rsp_valid the same way, and req_ready
// returns in the same cycle as rsp_valid. One command is in flight at a
// time; req_ready is high whenever the sequencer is idle.
// Reset empties both tables at once through their fill counts and clears
// the default handler registers; there is no clearing pass.
// A result waiting in the rsp register does not block the next command;
// if the receiver stalls, the following result holds in the sequencer
// until the rsp register frees.
`default_nettype none
module can_id_dispatch_table #(
   parameter int ENTRIES = cidt_pkg::ENTRIES
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire cidt_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output cidt_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_write,
   input  wire logic                       csr_index,
   input  wire logic [cidt_pkg::HND_W-1:0] csr_wdata
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   cidt_pkg::cfg_type         cfg_ff, cfg_in;
   logic [CW-1:0]             exact_count;
   logic [CW-1:0]             range_count;
   logic                      exact_wr;
   logic                      range_wr;
   cidt_pkg::exact_entry_type exact_wr_data;
   cidt_pkg::range_entry_type range_wr_data;
   cidt_pkg::exact_entry_type exact_rd;
   cidt_pkg::range_entry_type range_rd;
   logic [AW-1:0]             rd_addr;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            cidt_pkg::CSR_DEFAULT_ENABLE:  cfg_in.enable  = csr_wdata[0];
            cidt_pkg::CSR_DEFAULT_HANDLER: cfg_in.handler = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cidt_table #(
      .ENTRIES (ENTRIES),
      .WIDTH   ($bits(cidt_pkg::exact_entry_type))
   ) u_exact (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (exact_wr),
      .wr_data (exact_wr_data),
      .rd_addr (rd_addr),
      .rd_data (exact_rd),
      .count   (exact_count)
   );

   cidt_table #(
      .ENTRIES (ENTRIES),
      .WIDTH   ($bits(cidt_pkg::range_entry_type))
   ) u_range (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (range_wr),
      .wr_data (range_wr_data),
      .rd_addr (rd_addr),
      .rd_data (range_rd),
      .count   (range_count)
   );

   cidt_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .cfg           (cfg_ff),
      .exact_count   (exact_count),
      .range_count   (range_count),
      .exact_wr      (exact_wr),
      .range_wr      (range_wr),
      .exact_wr_data (exact_wr_data),
      .range_wr_data (range_wr_data),
      .rd_addr       (rd_addr),
      .exact_rd      (exact_rd),
      .range_rd      (range_rd)
   );

endmodule
`default_nettype wire

>>> hdl/cidt_checker.sv
// Port-level checks of the dispatch table and their binding to the top level.
`default_nettype none
module cidt_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire cidt_pkg::rsp_type          rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transfer dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set straight after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in flight");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.match_kind == cidt_pkg::MATCH_NONE) |-> rsp_data.handler_out == '0)
      else $error("handler given without a match");

   a_full_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == cidt_pkg::STATUS_FULL)
         |-> rsp_data.match_kind == cidt_pkg::MATCH_NONE)
      else $error("full status reported on a lookup");

endmodule

bind can_id_dispatch_table cidt_checker u_checker (.*);
`default_nettype wire

>>> test/can_id_dispatch_table_tb.sv
// Self-checking testbench for the CAN identifier dispatch table: directed and random traffic.
module can_id_dispatch_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cidt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [cidt_pkg::ID_W-1:0] ID_TOP = 29'h1FFFFFFF;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   cidt_pkg::req_type          req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   cidt_pkg::rsp_type          rsp_data;
   logic                       csr_write = 1'b0;
   logic                       csr_index = 1'b0;
   logic [cidt_pkg::HND_W-1:0] csr_wdata = '0;

   can_id_dispatch_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // routing state mirrored by the testbench
   logic [cidt_pkg::ID_W-1:0]  exact_id    [cidt_pkg::ENTRIES];
   logic [cidt_pkg::HND_W-1:0] exact_hnd   [cidt_pkg::ENTRIES];
   int                         exact_fill = 0;
   logic [cidt_pkg::ID_W-1:0]  span_start  [cidt_pkg::ENTRIES];
   logic [cidt_pkg::LEN_W-1:0] span_len    [cidt_pkg::ENTRIES];
   logic [cidt_pkg::HND_W-1:0] span_hnd    [cidt_pkg::ENTRIES];
   int                         span_fill = 0;
   logic                       dflt_en = 1'b0;
   logic [cidt_pkg::HND_W-1:0] dflt_hnd = '0;

   cidt_pkg::req_type          cmd_q[$];
   cidt_pkg::rsp_type          route_q[$];
   logic [cidt_pkg::ID_W-1:0]  id_pool[$];
   cidt_pkg::rsp_type          want;

   logic req_fire = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   n_cycles = 0;
   int   n_err = 0;
   int   n_xfer = 0;
   int   n_full = 0;
   int   n_cfg = 0;
   int   n_kind[4] = '{0, 0, 0, 0};

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic cidt_pkg::rsp_type route_predict(input cidt_pkg::req_type r);
      cidt_pkg::rsp_type          res;
      logic [cidt_pkg::ID_W+1:0]  last;
      bit                         hit;
      int                         i;
      res = '0;
      hit = 1'b0;
      case (r.cmd)
         cidt_pkg::CMD_LOOKUP: begin
            for (i = 0; i < exact_fill; i++) begin
               if (!hit && exact_id[i] == r.can_id) begin
                  hit = 1'b1;
                  res.match_kind = cidt_pkg::MATCH_EXACT;
                  res.handler_out = exact_hnd[i];
               end
            end
            for (i = 0; i < span_fill; i++) begin
               last = {2'b00, span_start[i]} + {1'b0, span_len[i]} - 31'd1;
               if (!hit && span_len[i] != '0 && r.can_id >= span_start[i]
                   && {2'b00, r.can_id} <= last) begin
                  hit = 1'b1;
                  res.match_kind = cidt_pkg::MATCH_RANGE;
                  res.handler_out = span_hnd[i];
               end
            end
            if (!hit && dflt_en) begin
               res.match_kind = cidt_pkg::MATCH_DEFAULT;
               res.handler_out = dflt_hnd;
            end
         end
         cidt_pkg::CMD_ADD_EXACT: begin
            if (exact_fill >= cidt_pkg::ENTRIES) begin
               res.status = cidt_pkg::STATUS_FULL;
            end else begin
               exact_id[exact_fill] = r.can_id;
               exact_hnd[exact_fill] = r.handler;
               exact_fill++;
            end
         end
         cidt_pkg::CMD_ADD_RANGE: begin
            if (span_fill >= cidt_pkg::ENTRIES) begin
               res.status = cidt_pkg::STATUS_FULL;
            end else begin
               span_start[span_fill] = r.can_id;
               span_len[span_fill] = r.range_len;
               span_hnd[span_fill] = r.handler;
               span_fill++;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void push_cmd(input logic [cidt_pkg::CMD_W-1:0] cmd,
                                    input logic [cidt_pkg::ID_W-1:0] id,
                                    input logic [cidt_pkg::LEN_W-1:0] len,
                                    input logic [cidt_pkg::HND_W-1:0] hnd);
      cidt_pkg::req_type r;
      r.cmd = cmd;
      r.can_id = id;
      r.range_len = len;
      r.handler = hnd;
      cmd_q = {cmd_q, r};
      if (cmd == cidt_pkg::CMD_ADD_EXACT) begin
         id_pool = {id_pool, id};
      end else if (cmd == cidt_pkg::CMD_ADD_RANGE) begin
         id_pool = {id_pool, id, id - 29'd1,
                    id + cidt_pkg::ID_W'(len) - 29'd1, id + cidt_pkg::ID_W'(len)};
      end
   endfunction

   function automatic logic [cidt_pkg::ID_W-1:0] pick_id();
      logic [cidt_pkg::ID_W-1:0] v;
      int                        sel;
      sel = $urandom_range(99);
      if (id_pool.size() == 0 || sel < 30) begin
         v = cidt_pkg::ID_W'($urandom);
      end else begin
         v = id_pool[$urandom_range(id_pool.size() - 1)];
         if (sel >= 60) v = v + cidt_pkg::ID_W'($urandom_range(4)) - 29'd2;
      end
      return v;
   endfunction

   function automatic void push_random();
      int                         sel;
      int                         k;
      logic [cidt_pkg::ID_W-1:0]  start;
      logic [cidt_pkg::LEN_W-1:0] len;
      sel = $urandom_range(99);
      if (sel < 6) begin
         push_cmd(cidt_pkg::CMD_ADD_EXACT, pick_id(), cidt_pkg::LEN_W'($urandom),
                  cidt_pkg::HND_W'($urandom));
      end else if (sel < 12) begin
         k = $urandom_range(99);
         if (k < 10) begin
            start = pick_id();
            len = '0;
         end else if (k < 65) begin
            start = pick_id();
            len = cidt_pkg::LEN_W'($urandom_range(64, 1));
         end else if (k < 90) begin
            start = cidt_pkg::ID_W'($urandom);
            len = cidt_pkg::LEN_W'($urandom_range(1 << 20, 65));
         end else begin
            start = ID_TOP - cidt_pkg::ID_W'($urandom_range(4095));
            len = cidt_pkg::LEN_W'($urandom);
         end
         push_cmd(cidt_pkg::CMD_ADD_RANGE, start, len, cidt_pkg::HND_W'($urandom));
      end else if (sel < 15) begin
         push_cmd(CMD_UNUSED, cidt_pkg::ID_W'($urandom), cidt_pkg::LEN_W'($urandom),
                  cidt_pkg::HND_W'($urandom));
      end else begin
         push_cmd(cidt_pkg::CMD_LOOKUP, pick_id(), cidt_pkg::LEN_W'($urandom),
                  cidt_pkg::HND_W'($urandom));
      end
   endfunction

   task automatic write_csr(input logic idx, input logic [cidt_pkg::HND_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == cidt_pkg::CSR_DEFAULT_ENABLE) dflt_en = val[0];
      else dflt_hnd = val;
      n_cfg++;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (cmd_q.size() != 0 || req_valid || route_q.size() != 0);
   endtask

   task automatic run_phase(input int n, input logic en, input logic [cidt_pkg::HND_W-1:0] hnd,
                            input int send_pct, input int recv_pct, input bit bursts);
      int sent;
      int k;
      write_csr(cidt_pkg::CSR_DEFAULT_ENABLE, {7'd0, en});
      write_csr(cidt_pkg::CSR_DEFAULT_HANDLER, hnd);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      while (sent < n) begin
         k = bursts ? $urandom_range(8, 1) : n;
         repeat (k) push_random();
         sent += k;
         if (bursts) wait_idle();
      end
      wait_idle();
   endtask

   // drive request: hold until transfer, then advance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= cmd_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= $urandom_range(99) >= recv_stall_pct;
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         want = route_predict(req_data);
         route_q = {route_q, want};
         n_xfer++;
         if (req_data.cmd == cidt_pkg::CMD_LOOKUP) n_kind[want.match_kind]++;
         if (want.status == cidt_pkg::STATUS_FULL) n_full++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (route_q.size() == 0) begin
            $display("%0t: unexpected result status %0d kind %0d handler %0d", $time,
                     rsp_data.status, rsp_data.match_kind, rsp_data.handler_out);
            n_err++;
         end else begin
            want = route_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.match_kind !== want.match_kind
                || rsp_data.handler_out !== want.handler_out) begin
               $display("%0t: expected status %0d kind %0d handler %0d, got %0d %0d %0d",
                        $time, want.status, want.match_kind, want.handler_out,
                        rsp_data.status, rsp_data.match_kind, rsp_data.handler_out);
               n_err++;
            end
         end
      end
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles == CYCLE_LIMIT) begin
         $display("can_id_dispatch_table: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      write_csr(cidt_pkg::CSR_DEFAULT_ENABLE, 8'd0);
      write_csr(cidt_pkg::CSR_DEFAULT_HANDLER, 8'hA5);
      push_cmd(cidt_pkg::CMD_LOOKUP, '0, '0, '0);
      push_cmd(CMD_UNUSED, ID_TOP, '1, '1);
      push_cmd(cidt_pkg::CMD_ADD_EXACT, '0, '1, 8'h11);
      push_cmd(cidt_pkg::CMD_ADD_EXACT, ID_TOP, '0, 8'hFF);
      push_cmd(cidt_pkg::CMD_ADD_EXACT, '0, '0, 8'h22);
      push_cmd(cidt_pkg::CMD_ADD_RANGE, 29'h100, '0, 8'h33);
      push_cmd(cidt_pkg::CMD_ADD_RANGE, 29'h100, 30'h10, 8'h44);
      push_cmd(cidt_pkg::CMD_ADD_RANGE, ID_TOP - 29'd15, 30'h20000000, 8'h55);
      push_cmd(cidt_pkg::CMD_ADD_RANGE, 29'h1000, 30'h1, 8'h66);
      push_cmd(cidt_pkg::CMD_LOOKUP, '0, '0, '0);
      push_cmd(cidt_pkg::CMD_LOOKUP, ID_TOP, '0, '0);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h100, '0, '0);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h10F, '1, '1);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h110, '0, '0);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h0FF, '0, '0);
      push_cmd(cidt_pkg::CMD_LOOKUP, ID_TOP - 29'd1, '0, '0);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h1000, '0, '0);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h1001, '0, '0);
      wait_idle();

      write_csr(cidt_pkg::CSR_DEFAULT_ENABLE, 8'd1);
      write_csr(cidt_pkg::CSR_DEFAULT_HANDLER, 8'hC3);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h110, '0, '0);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h1001, '0, '0);
      push_cmd(CMD_UNUSED, '0, '0, '0);
      wait_idle();
      write_csr(cidt_pkg::CSR_DEFAULT_HANDLER, 8'h00);
      push_cmd(cidt_pkg::CMD_LOOKUP, 29'h0FF, '0, '0);
      wait_idle();

      run_phase(200, 1'b1, 8'hFF, 0, 0, 1'b0);
      run_phase(200, 1'b0, 8'h5A, 84, 0, 1'b0);
      run_phase(200, 1'b1, 8'h00, 0, 84, 1'b0);
      run_phase(250, 1'b1, cidt_pkg::HND_W'($urandom), 32, 32, 1'b0);
      run_phase(150, 1'b0, cidt_pkg::HND_W'($urandom), 0, 0, 1'b1);
      run_phase(100, 1'b1, 8'hFF, 0, 0, 1'b0);

      repeat (60) @(negedge clock);
      $display("Run covered %0d transfers and %0d register writes; %0d adds refused as full.",
               n_xfer, n_cfg, n_full);
      $display("Lookups resolved: %0d exact, %0d range, %0d default, %0d unmatched.",
               n_kind[cidt_pkg::MATCH_EXACT], n_kind[cidt_pkg::MATCH_RANGE],
               n_kind[cidt_pkg::MATCH_DEFAULT], n_kind[cidt_pkg::MATCH_NONE]);
      if (n_err == 0) begin
         $display("can_id_dispatch_table: match");
      end else begin
         $display("can_id_dispatch_table: mismatch");
      end
      $finish;
   end

endmodule
